// ===== src/smx_pkg.sv =====
// Shared widths, constants and the fractional power-of-two table for the softmax normalizer.
package smx_pkg;

  localparam int unsigned DATA_W  = 16;  // logit and probability width
  localparam int unsigned FRAC_W  = 16;  // quotient bits produced by the divider
  localparam int unsigned PROD_W  = 25;  // 16-bit difference times 9-bit log2(e)
  localparam int unsigned LOG2E_W = 9;

  // log2(e) in Q1.8
  localparam logic [LOG2E_W-1:0] LOG2E_Q8 = 9'd369;

  // round(65536 * 2^(-k/16)), with 1.0 saturated to 65535
  function automatic logic [DATA_W-1:0] pow2_frac(input logic [3:0] k);
    logic [DATA_W-1:0] v;
    unique case (k)
      4'd0:    v = 16'd65535;
      4'd1:    v = 16'd62757;
      4'd2:    v = 16'd60097;
      4'd3:    v = 16'd57549;
      4'd4:    v = 16'd55109;
      4'd5:    v = 16'd52773;
      4'd6:    v = 16'd50535;
      4'd7:    v = 16'd48393;
      4'd8:    v = 16'd46341;
      4'd9:    v = 16'd44376;
      4'd10:   v = 16'd42495;
      4'd11:   v = 16'd40693;
      4'd12:   v = 16'd38968;
      4'd13:   v = 16'd37316;
      4'd14:   v = 16'd35734;
      default: v = 16'd34219;
    endcase
    return v;
  endfunction

endpackage

// ===== src/smx_divider.sv =====
// Bit-serial restoring divider: floor(num * 2^16 / den), saturated, one quotient bit per cycle.
module smx_divider #(
  parameter int unsigned SUM_W = 19
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [smx_pkg::DATA_W-1:0]    num_i,
  input  logic [SUM_W-1:0]              den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [smx_pkg::FRAC_W-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(smx_pkg::FRAC_W + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SUM_W-1:0]           rem_q, rem_d;
  logic [SUM_W-1:0]           den_q, den_d;
  logic [smx_pkg::FRAC_W-1:0] quot_q, quot_d;

  logic [SUM_W:0] rem_x2;
  logic [SUM_W:0] rem_sub;
  logic [SUM_W-1:0] num_ext;

  assign num_ext = SUM_W'(num_i);
  assign rem_x2  = {rem_q, 1'b0};
  assign rem_sub = rem_x2 - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      den_d  = den_i;
      rem_d  = num_ext;
      quot_d = '0;
      cnt_d  = CNT_W'(smx_pkg::FRAC_W);
      // A term equal to the whole sum gives exactly 1.0: saturate, no iteration.
      if (den_i == '0) begin
        cnt_d = '0;
      end else if (num_ext == den_i) begin
        quot_d = '1;
        cnt_d  = '0;
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
        if (!rem_sub[SUM_W]) begin
          rem_d  = rem_sub[SUM_W-1:0];
          quot_d = {quot_q[smx_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_x2[SUM_W-1:0];
          quot_d = {quot_q[smx_pkg::FRAC_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(start_i) && cnt_q != '0 && den_q != '0) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== src/softmax_normalizer_core.sv =====
// Top level of the softmax normalizer: load, exponent pass and serial normalization.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | logit_i (s16 Q8.8), logit_last_i
//   out     | output    | out_valid_o/out_ready_i | probability_o (u16 Q0.16), prob_last_o
//
// Loading takes one logit per cycle. After the marked logit, each stored element
// passes through the exponent pass (memory read, multiply by log2(e), table and
// shift), then each result goes through read, divider start, 16 quotient steps,
// the finish, the done handoff and the put. A term equal to the whole sum
// saturates with no quotient steps.
// Reset clears the counters, the running maximum and the sum; the stores need none.
// A stalled output holds its register; the sequencer waits before loading the next
// result, and new logits are taken once the last result sits in the output register.
module softmax_normalizer_core #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] logit_i,
  input  logic        logit_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] probability_o,
  output logic        prob_last_o
);

  localparam int unsigned DW    = smx_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned SUM_W = $clog2(MAX_LEN) + DW;  // holds MAX_LEN * 65535

  // sequencer states
  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_EXP_RD   = 3'd1;
  localparam logic [2:0] ST_EXP_MUL  = 3'd2;
  localparam logic [2:0] ST_EXP_ACC  = 3'd3;
  localparam logic [2:0] ST_DIV_RD   = 3'd4;
  localparam logic [2:0] ST_DIV_GO   = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;
  localparam logic [2:0] ST_PUT      = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic signed [DW-1:0]   max_q, max_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   out_valid_q, out_valid_d;
  logic [DW-1:0]          prob_q;
  logic                   prob_last_q;

  // element stores, registered reads
  logic [DW-1:0] logit_mem [MAX_LEN];
  logic [DW-1:0] exp_mem   [MAX_LEN];
  logic [DW-1:0] logit_rd_q;
  logic [DW-1:0] exp_rd_q;

  logic [smx_pkg::PROD_W-1:0] prod_q;

  logic               in_xfer;
  logic               room;
  logic               idx_is_last;
  logic [DW:0]        diff_wide;
  logic [DW-1:0]      exp_val;
  logic               put_ok;
  logic               exp_we;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DW-1:0]      div_quot;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign room        = (count_q < CNT_W'(MAX_LEN));
  assign idx_is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign put_ok      = !out_valid_q || out_ready_i;
  assign exp_we      = (state_q == ST_EXP_ACC);
  assign div_start   = (state_q == ST_DIV_GO);

  // d = max - logit is never negative, so the low 16 bits are the unsigned difference
  assign diff_wide = {max_q[DW-1], max_q} - {logit_rd_q[DW-1], logit_rd_q};

  // e = table[k] >> n, zero once the integer part n reaches 16
  always_comb begin
    if (prod_q[smx_pkg::PROD_W-1:20] != '0) begin
      exp_val = '0;
    end else begin
      exp_val = smx_pkg::pow2_frac(prod_q[15:12]) >> prod_q[19:16];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    max_d       = max_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          // drop logits beyond the store; a dropped marked logit still closes the vector
          if (room) begin
            count_d = count_q + CNT_W'(1);
            if ($signed(logit_i) > max_q) begin
              max_d = $signed(logit_i);
            end
          end
          if (logit_last_i) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = ST_EXP_RD;
          end
        end
      end
      ST_EXP_RD:  state_d = ST_EXP_MUL;
      ST_EXP_MUL: state_d = ST_EXP_ACC;
      ST_EXP_ACC: begin
        sum_d = sum_q + SUM_W'(exp_val);
        if (idx_is_last) begin
          idx_d   = '0;
          state_d = ST_DIV_RD;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_EXP_RD;
        end
      end
      ST_DIV_RD:  state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_ok) begin
          out_valid_d = 1'b1;
          if (idx_is_last) begin
            // vector done: back to the reset values
            count_d = '0;
            max_d   = {1'b1, {(DW-1){1'b0}}};
            sum_d   = '0;
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_DIV_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      idx_q       <= '0;
      max_q       <= {1'b1, {(DW-1){1'b0}}};
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stores and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && room) begin
      logit_mem[count_q[IDX_W-1:0]] <= logit_i;
    end
    if (exp_we) begin
      exp_mem[idx_q] <= exp_val;
    end
    logit_rd_q <= logit_mem[idx_q];
    exp_rd_q   <= exp_mem[idx_q];
    prod_q     <= smx_pkg::PROD_W'(diff_wide[DW-1:0]) *
                  smx_pkg::PROD_W'(smx_pkg::LOG2E_Q8);
    if (state_q == ST_PUT && put_ok) begin
      prob_q      <= div_quot;
      prob_last_q <= idx_is_last;
    end
  end

  smx_divider #(
    .SUM_W (SUM_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (exp_rd_q),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign prob_last_o   = prob_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_LEN))
    else $error("element count beyond store depth");

  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_GO) |-> (sum_q != '0))
    else $error("normalizing with a zero exponent sum");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (CNT_W'(idx_q) < count_q))
    else $error("element index beyond loaded count");

  a_done_to_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_WAIT && div_done) |=> (state_q == ST_PUT))
    else $error("divider result not taken");

  a_load_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("accepting logits while dividing");

endmodule

// ===== test/softmax_normalizer_core_tb.sv =====
// Testbench for softmax_normalizer_core: directed and random vectors against a softmax predictor.
module softmax_normalizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_W       = smx_pkg::DATA_W;
  localparam int unsigned VEC_MAX      = 8;       // matches the default MAX_LEN of the core
  localparam int unsigned RANDOM_ITEMS = 90;
  localparam int unsigned SETTLE_CYCLES = 100;    // quiet time after the last probability
  localparam int unsigned CYCLE_LIMIT  = 300000;  // far above the slowest legal run

  typedef struct packed {
    logic [DATA_W-1:0] probability;
    logic              last;
  } prob_t;

  // round(65536 * 2^(-k/16)), with 1.0 held at 65535
  logic [DATA_W-1:0] pow2_lut [16] = '{
    16'd65535, 16'd62757, 16'd60097, 16'd57549, 16'd55109, 16'd52773, 16'd50535, 16'd48393,
    16'd46341, 16'd44376, 16'd42495, 16'd40693, 16'd38968, 16'd37316, 16'd35734, 16'd34219
  };

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [DATA_W-1:0] logit_i      = '0;
  logic              logit_last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [DATA_W-1:0] probability_o;
  logic              prob_last_o;

  // Predictor state: the vector being loaded and its running maximum.
  logic signed [DATA_W-1:0] vec_logits [VEC_MAX];
  int unsigned              vec_len = 0;
  logic signed [DATA_W-1:0] vec_max = 16'sh8000;

  prob_t       expected_probs [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_limit      = 10;  // longest sender pause before an item
  int unsigned stall_limit    = 10;  // longest receiver stall before a result
  int unsigned stall_left     = 0;

  softmax_normalizer_core #(
    .MAX_LEN(VEC_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .logit_i      (logit_i),
    .logit_last_i (logit_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .probability_o(probability_o),
    .prob_last_o  (prob_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the core hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Fold one accepted logit into the predicted vector. On the marked logit,
  // exponentiate every stored element against the maximum, normalize, and queue
  // one expected probability per stored element.
  function automatic void predict_softmax(input logic [DATA_W-1:0] raw, input logic last);
    logic signed [DATA_W-1:0] x;
    int unsigned              exps [VEC_MAX];
    int unsigned              total;
    int unsigned              diff;
    int unsigned              scaled;
    longint unsigned          quot;
    prob_t                    r;
    x = raw;
    // Drop anything past a full vector; it must not move the maximum either.
    if (vec_len < VEC_MAX) begin
      vec_logits[vec_len] = x;
      vec_len++;
      if (x > vec_max) vec_max = x;
    end
    if (!last) return;
    total = 0;
    for (int unsigned i = 0; i < vec_len; i++) begin
      diff   = int'(vec_max) - int'(vec_logits[i]);
      scaled = diff * 369;  // base-2 exponent in Q16.16
      if ((scaled >> 16) >= 16) exps[i] = 0;
      else exps[i] = pow2_lut[(scaled >> 12) & 15] >> (scaled >> 16);
      total += exps[i];
    end
    for (int unsigned i = 0; i < vec_len; i++) begin
      quot = 0;
      if (total != 0) begin
        quot = (longint'(exps[i]) << 16) / total;
        if (quot > 65535) quot = 65535;
      end
      r.probability = quot[DATA_W-1:0];
      r.last        = (i + 1 == vec_len);
      expected_probs.push_back(r);
    end
    // Start the next vector from scratch.
    vec_len = 0;
    vec_max = 16'sh8000;
  endfunction

  // Offer one logit after a random pause and hold it until the transfer.
  // Valid stays high across back-to-back items, so it is only lowered on a pause.
  task automatic send_logit(input logic [DATA_W-1:0] value, input logic last);
    int unsigned gap;
    gap = $urandom_range(gap_limit, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    logit_i      <= value;
    logit_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_softmax(value, last);
  endtask

  // Hold the input idle until every queued probability has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_probs.size() != 0);
  endtask

  // Receiver: after each transfer draw a fresh stall, then raise ready again.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned draw;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_ready_i && out_valid_o) begin
      draw = $urandom_range(stall_limit, 0);
      if (draw != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= draw - 1;
      end
    end else if (!out_ready_i) begin
      if (stall_left == 0) out_ready_i <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Compare every output transfer with the oldest expected probability.
  always @(posedge clk_i) begin
    prob_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_probs.size() == 0) begin
        report_mismatch($sformatf("unexpected probability %0d last %0b",
                                  probability_o, prob_last_o));
      end else begin
        want = expected_probs.pop_front();
        if (probability_o !== want.probability)
          report_mismatch($sformatf("probability %0d, expected %0d",
                                    probability_o, want.probability));
        if (prob_last_o !== want.last)
          report_mismatch($sformatf("last marker %0b, expected %0b",
                                    prob_last_o, want.last));
      end
    end
  end

  // Single-element vectors at the extremes, a full-range pair, and the pair of
  // differences on either side of the point where the exponent underflows to zero.
  task automatic test_extremes();
    send_logit(16'h7FFF, 1'b1);
    send_logit(16'h8000, 1'b1);
    send_logit(16'h0000, 1'b1);
    send_logit(16'h8000, 1'b0);
    send_logit(16'h7FFF, 1'b1);
    send_logit(16'h0B19, 1'b0);  // difference 2841: smallest nonzero exponent
    send_logit(16'h0000, 1'b1);
    send_logit(16'h0B1A, 1'b0);  // difference 2842: exponent becomes zero
    send_logit(16'h0000, 1'b1);
  endtask

  // Equal logits split the mass evenly; run this one with no idling at all.
  task automatic test_equal_logits();
    gap_limit   = 0;
    stall_limit = 0;
    for (int unsigned i = 0; i < 4; i++) send_logit(16'h1234, i == 3);
    gap_limit   = 10;
    stall_limit = 10;
  endtask

  // Fill the vector, then push three more: the large dropped logits must not
  // change the maximum, and the dropped marked one still closes the vector.
  task automatic test_overlong_vector();
    for (int unsigned i = 0; i < VEC_MAX; i++) send_logit(16'h0100 + 16'(i * 16'h0040), 1'b0);
    send_logit(16'h7FFF, 1'b0);
    send_logit(16'h8000, 1'b0);
    send_logit(16'h7FFF, 1'b1);
  endtask

  // Let the core drain completely, then resume back to back.
  task automatic test_drain_pause();
    send_logit(16'hFF00, 1'b0);
    send_logit(16'h0080, 1'b0);
    send_logit(16'h0000, 1'b1);
    wait_drained();
    gap_limit = 0;
    send_logit(16'h0200, 1'b0);
    send_logit(16'hFE00, 1'b1);
    gap_limit = 10;
  endtask

  // Mostly well-formed vectors of 1 to 8 logits, some overlong ones. Logits are
  // either full range or clustered so that several exponents stay nonzero.
  task automatic test_random_vectors();
    int unsigned       sent;
    int unsigned       len;
    int unsigned       spread;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] value;
    bit                wide;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3, 0) == 0) begin
        gap_limit   = 0;
        stall_limit = 0;
      end else begin
        gap_limit   = 10;
        stall_limit = 10;
      end
      len    = ($urandom_range(6, 0) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      wide   = ($urandom_range(2, 0) == 0);
      base   = 16'($urandom);
      spread = 1 << $urandom_range(12, 4);
      for (int unsigned i = 0; i < len; i++) begin
        value = wide ? 16'($urandom) : base + 16'($urandom_range(spread - 1, 0));
        send_logit(value, i == len - 1);
        sent++;
      end
    end
    gap_limit   = 10;
    stall_limit = 10;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_equal_logits();
    test_overlong_vector();
    test_drain_pause();
    test_random_vectors();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== softmax_normalizer_core.f =====
src/smx_pkg.sv
src/smx_divider.sv
src/softmax_normalizer_core.sv
test/softmax_normalizer_core_tb.sv
